[design/base64_stream_encoder_top_defines.svh]
// Assertion macros for the base64 stream encoder.
// Used by base64_stream_encoder_top; needs clk and arst_n in scope.
`ifndef BASE64_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64_STREAM_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTH
`define B64S_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("base64 encoder check failed");
`define B64S_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base64 encoder check failed");
`else
`define B64S_ASSERT(lbl, ante, cons)
`define B64S_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/b64s_pkg.sv]
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// No dependencies.
package b64s_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int GRP_W           = 24;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// One closed group of one to three bytes, bytes left-aligned
	typedef struct packed {
		logic [GRP_W-1:0] bits;
		logic [1:0]       n;
		logic             last;
	} grp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [1:0] held_count;
		logic       push;
	} front_stat_t;

	// Map a sextet to its character of the standard alphabet
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

[design/b64s_front.sv]
// Front end: accepts input beats, collects bytes into groups, pushes closed groups.
// Depends on b64s_pkg.
module b64s_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  data_valid,
	output logic                  data_stall,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_message,
	input  b64s_pkg::q_stat_t     q_stat,
	output logic                  push,
	output b64s_pkg::grp_t        push_grp,
	output b64s_pkg::front_stat_t stat
);
	import b64s_pkg::*;

	logic [15:0]      held_bytes_q;
	logic [1:0]       held_count_q;
	logic [GRP_W-1:0] grp;
	logic [1:0]       n;
	logic             close;
	logic             accept;

	// hold off input while the queue has no room
	assign data_stall = q_stat.full;
	assign accept     = data_valid && !data_stall;

	// merge the new byte with the waiting ones
	always_comb begin
		case (held_count_q)
			2'd0: begin
				grp = {data_byte, 16'h0000};
				n   = 2'd1;
			end
			2'd1: begin
				grp = {held_bytes_q[15:8], data_byte, 8'h00};
				n   = 2'd2;
			end
			default: begin
				grp = {held_bytes_q, data_byte};
				n   = 2'd3;
			end
		endcase
	end

	assign close         = (n == 2'd3) || end_of_message;
	assign push          = accept && close;
	assign push_grp.bits = grp;
	assign push_grp.n    = n;
	assign push_grp.last = end_of_message;

	// advance the byte collector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes_q <= '0;
			held_count_q <= '0;
		end else if (accept) begin
			if (close) begin
				held_bytes_q <= '0;
				held_count_q <= '0;
			end else begin
				held_bytes_q <= grp[GRP_W-1:8];
				held_count_q <= n;
			end
		end
	end

	assign stat.held_count = held_count_q;
	assign stat.push       = push;

endmodule

[design/b64s_queue.sv]
// Short register queue of closed groups between front and back.
// Depends on b64s_pkg.
module b64s_queue #(
	parameter int DEPTH = b64s_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64s_pkg::grp_t    push_grp,
	input  logic              pop,
	output b64s_pkg::grp_t    pop_grp,
	output b64s_pkg::q_stat_t stat
);
	import b64s_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	grp_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_grp    = entry_q[rd_ptr_q];

	// store pushed groups
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_grp;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/b64s_back.sv]
// Back end: takes groups from the queue and sends four characters per group.
// Depends on b64s_pkg.
module b64s_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64s_pkg::q_stat_t q_stat,
	input  b64s_pkg::grp_t    pop_grp,
	output logic              pop,
	output logic              char_valid,
	input  logic              char_stall,
	output logic [7:0]        out_char,
	output logic              last_char
);
	import b64s_pkg::*;

	grp_t       cur_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       char_valid_q;
	logic [7:0] out_char_q;
	logic       last_char_q;
	logic       advance;
	logic [5:0] sextet;
	logic       pad;
	logic [7:0] next_char;

	assign advance = !char_valid_q || !char_stall;
	assign pop     = !q_stat.empty && (!busy_q || (advance && idx_q == 2'd3));

	// pick the sextet for the current position
	always_comb begin
		case (idx_q)
			2'd0:    sextet = cur_q.bits[23:18];
			2'd1:    sextet = cur_q.bits[17:12];
			2'd2:    sextet = cur_q.bits[11:6];
			default: sextet = cur_q.bits[5:0];
		endcase
	end

	assign pad = ((idx_q == 2'd2) && (cur_q.n == 2'd1)) ||
	             ((idx_q == 2'd3) && (cur_q.n != 2'd3));
	assign next_char = pad ? PAD_CHAR : b64_char(sextet);

	// load the next group
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_grp;
		end
	end

	// step through the group and drive the output register;
	// idx_q wraps to zero at the end of each group, so a new group starts at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			idx_q        <= '0;
			char_valid_q <= 1'b0;
			out_char_q   <= '0;
			last_char_q  <= 1'b0;
		end else begin
			if (advance) begin
				char_valid_q <= busy_q;
				if (busy_q) begin
					out_char_q  <= next_char;
					last_char_q <= cur_q.last && (idx_q == 2'd3);
					idx_q       <= idx_q + 1'b1;
				end
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && busy_q && (idx_q == 2'd3)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign char_valid = char_valid_q;
	assign out_char   = out_char_q;
	assign last_char  = last_char_q;

endmodule

[design/base64_stream_encoder_top.sv]
// Top level of the base64 stream encoder: front, group queue and back.
// Depends on b64s_pkg, b64s_front, b64s_queue, b64s_back and the defines header.

// Encodes a byte stream as base64 (standard alphabet, '=' padding). One byte is
// taken per beat on the data channel; end_of_message closes the message, and
// last_char flags its final character. Characters leave one per cycle from an
// output register while char_stall is low, four per group of three bytes, so
// the character channel sets the sustained rate. Bytes are taken every cycle
// while the group queue (QUEUE_DEPTH groups) has room. The closing byte's group
// passes the queue and the back's group register before its first character.
`include "base64_stream_encoder_top_defines.svh"

module base64_stream_encoder_top #(
	parameter int QUEUE_DEPTH = b64s_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [7:0] out_char,
	output logic       last_char
);
	import b64s_pkg::*;

	q_stat_t     q_stat;
	front_stat_t front_stat;
	grp_t        push_grp;
	grp_t        pop_grp;
	logic        push;
	logic        pop;

	b64s_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_valid     (data_valid),
		.data_stall     (data_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.q_stat         (q_stat),
		.push           (push),
		.push_grp       (push_grp),
		.stat           (front_stat)
	);

	b64s_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.pop_grp  (pop_grp),
		.stat     (q_stat)
	);

	b64s_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_grp    (pop_grp),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.out_char   (out_char),
		.last_char  (last_char)
	);

	// the collector never holds a full group
	`B64S_ASSERT(a_held_below_three, 1'b1, front_stat.held_count != 2'd3)
	// a push never lands on a full queue
	`B64S_ASSERT(a_no_push_full, front_stat.push, !q_stat.full)
	// the back only pops stored groups
	`B64S_ASSERT(a_no_pop_empty, pop, !q_stat.empty)
	// a closing push leaves the collector empty
	`B64S_ASSERT_NEXT(a_push_clears, front_stat.push, front_stat.held_count == 2'd0)

endmodule

[tb/base64_stream_encoder_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_encoder_top: directed table, then random messages.
// Depends on b64s_pkg and base64_stream_encoder_top; predicts every character on its own.

module base64_stream_encoder_top_tb;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 4;
	localparam int RANDOM_BYTES  = 88;
	localparam int QUIET_TAIL    = 20;
	localparam int LONG_HOLD     = 120;
	localparam int DRAIN_CYCLES  = 10;
	localparam int CYCLE_LIMIT   = 60000;

	localparam logic [511:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_exp_t;

	typedef struct {
		logic [7:0]  b;
		logic        eom;
		bit          typed;
		logic [31:0] chars;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       data_valid;
	logic       data_stall;
	logic [7:0] data_byte;
	logic       end_of_message;
	logic       char_valid;
	logic       char_stall = 1'b0;
	logic [7:0] out_char;
	logic       last_char;

	// Encoder state as the predictor sees it
	logic [15:0] held_bytes;
	logic [1:0]  held_count;

	char_exp_t pending_chars[$];
	dir_row_t  dir_rows[$];

	int  fail_count    = 0;
	int  chars_checked = 0;
	int  bytes_sent    = 0;
	int  messages_sent = 0;
	int  cycles        = 0;
	bit  quiet         = 1'b0;
	int  hold_requests = 0;
	int  holds_served  = 0;
	int  hold_left     = 0;
	int  burst_left    = 0;

	base64_stream_encoder_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_valid     (data_valid),
		.data_stall     (data_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.out_char       (out_char),
		.last_char      (last_char)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still due", cycles,
				pending_chars.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
		return ALPHABET[511 - 8 * v -: 8];
	endfunction

	// Advance the encoder state by one byte; return the four characters of a closed group
	function automatic void encode_byte(input logic [7:0] b, input logic eom,
			output logic [31:0] chars, output bit closed);
		logic [23:0] grp;
		int n;
		case (held_count)
			2'd0: begin
				grp = {b, 16'h0000};
				n = 1;
			end
			2'd1: begin
				grp = {held_bytes[15:8], b, 8'h00};
				n = 2;
			end
			default: begin
				grp = {held_bytes, b};
				n = 3;
			end
		endcase
		closed = (n == 3) || eom;
		chars = {sextet_ascii(grp[23:18]), sextet_ascii(grp[17:12]),
			(n >= 2) ? sextet_ascii(grp[11:6]) : b64s_pkg::PAD_CHAR,
			(n >= 3) ? sextet_ascii(grp[5:0]) : b64s_pkg::PAD_CHAR};
		if (closed) begin
			held_bytes = 16'h0000;
			held_count = 2'd0;
		end else begin
			held_bytes = grp[23:8];
			held_count = n[1:0];
		end
	endfunction

	task automatic add_row(input logic [7:0] b, input logic eom, input bit typed,
			input logic [31:0] chars);
		dir_row_t r;
		r.b = b;
		r.eom = eom;
		r.typed = typed;
		r.chars = chars;
		dir_rows.push_back(r);
	endtask

	// Offer one byte beat, wait for it to be taken, then queue what it should produce
	task automatic send_beat(input logic [7:0] b, input logic eom, input bit typed,
			input logic [31:0] typed_chars);
		int gap;
		logic [31:0] chars;
		bit closed;
		char_exp_t e;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			data_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		end_of_message <= eom;
		do @(posedge clk); while (data_stall);
		encode_byte(b, eom, chars, closed);
		if (typed)
			chars = typed_chars;
		if (closed) begin
			for (int i = 0; i < 4; i++) begin
				e.ch = chars[31 - 8 * i -: 8];
				e.last = eom && (i == 3);
				pending_chars.push_back(e);
			end
		end
		bytes_sent++;
		if (eom)
			messages_sent++;
		@(negedge clk);
	endtask

	// Drive the character stall: long hold on request, short random bursts otherwise
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served <= hold_requests;
			hold_left <= LONG_HOLD - 1;
			char_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			char_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left <= burst_left - 1;
			char_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			burst_left <= $urandom_range(1, 5) - 1;
			char_stall <= 1'b1;
		end else begin
			char_stall <= 1'b0;
		end
	end

	// Compare each accepted character beat with the oldest expectation
	always @(posedge clk) begin
		char_exp_t e;
		if (arst_n && char_valid && !char_stall) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character beat: out_char %h last_char %b",
					out_char, last_char);
				fail_count++;
			end else begin
				e = pending_chars.pop_front();
				chars_checked++;
				if (out_char !== e.ch) begin
					$error("out_char mismatch: expected %h, got %h", e.ch, out_char);
					fail_count++;
				end
				if (last_char !== e.last) begin
					$error("last_char mismatch: expected %b, got %b", e.last, last_char);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int len;
		int sent;
		logic [7:0] b;
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_byte = 8'h00;
		end_of_message = 1'b0;
		held_bytes = 16'h0000;
		held_count = 2'd0;

		// Extremes, padding of one and two, full groups, '+' and '/'
		add_row(8'h00, 1'b1, 1'b1, "AA==");
		add_row(8'hFF, 1'b1, 1'b1, "/w==");
		add_row(8'hFF, 1'b0, 1'b0, 32'h0);
		add_row(8'hFF, 1'b1, 1'b1, "//8=");
		add_row(8'hFF, 1'b0, 1'b0, 32'h0);
		add_row(8'hFF, 1'b0, 1'b0, 32'h0);
		add_row(8'hFF, 1'b1, 1'b1, "////");
		add_row(8'h00, 1'b0, 1'b0, 32'h0);
		add_row(8'h00, 1'b0, 1'b0, 32'h0);
		add_row(8'h00, 1'b0, 1'b1, "AAAA");
		add_row(8'h4D, 1'b0, 1'b0, 32'h0);
		add_row(8'h61, 1'b0, 1'b0, 32'h0);
		add_row(8'h6E, 1'b1, 1'b0, 32'h0);
		add_row(8'hFB, 1'b0, 1'b0, 32'h0);
		add_row(8'hEF, 1'b0, 1'b0, 32'h0);
		add_row(8'hBE, 1'b0, 1'b0, 32'h0);
		add_row(8'h01, 1'b0, 1'b0, 32'h0);
		add_row(8'h02, 1'b1, 1'b0, 32'h0);
		add_row(8'hA5, 1'b0, 1'b0, 32'h0);
		add_row(8'h5A, 1'b0, 1'b0, 32'h0);
		add_row(8'hC3, 1'b0, 1'b0, 32'h0);
		add_row(8'h3C, 1'b1, 1'b0, 32'h0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].b, dir_rows[i].eom, dir_rows[i].typed, dir_rows[i].chars);

		// Hold the character side off while bytes keep coming, to back up the input
		hold_requests++;

		// Random messages, mostly short, a few long; the last one is cut to fit
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) < 7)
				len = $urandom_range(1, 6);
			else
				len = $urandom_range(7, 20);
			if (len > RANDOM_BYTES - sent)
				len = RANDOM_BYTES - sent;
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(0, 15))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				if (sent >= RANDOM_BYTES - QUIET_TAIL)
					quiet = 1'b1;
				send_beat(b, k == len - 1, 1'b0, 32'h0);
				sent++;
			end
		end
		data_valid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d messages, checked %0d characters, %0d failures",
			bytes_sent, messages_sent, chars_checked, fail_count);
		$display("covered padding of one and two, full groups, a long output hold-off");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
